>>> design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define LSGC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define LSGC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/lsgc_pkg.sv
// Shared constants, types and the arctangent table of the scan to grid block.
package lsgc_pkg;

   localparam int GRID_DIM_MAX = 4096;
   localparam int CORDIC_STEPS = 16;
   localparam int ROT_STEPS    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int STEP_W       = (ROT_STEPS > 1) ? $clog2(ROT_STEPS) : 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Start vector of the rotation, the inverse CORDIC gain in Q4.30.
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SKIP_PERIOD = 3'd0,
      CSR_ANGLE_START = 3'd1,
      CSR_ANGLE_STEP  = 3'd2,
      CSR_ORIGIN_X    = 3'd3,
      CSR_ORIGIN_Y    = 3'd4,
      CSR_CELL_SCALE  = 3'd5,
      CSR_GRID_WIDTH  = 3'd6,
      CSR_GRID_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [31:0]        cell_scale;
      logic [12:0]        grid_w;
      logic [12:0]        grid_h;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       rotate;
      logic [4:0] step;
      logic       scale;
      logic       offset;
      logic       mul;
      logic [1:0] mul_sel;
      logic       check;
      logic       index;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic out_free;
   } status_type;

   // Clamp a grid size register to the largest supported dimension.
   function automatic logic [12:0] clamp_dim(input logic [12:0] dim);
      logic [12:0] result;
      if (32'(dim) < 32'(GRID_DIM_MAX)) begin
         result = dim;
      end else begin
         result = 13'(GRID_DIM_MAX);
      end
      return result;
   endfunction

   // Arctangent of 2^-i in units of 2^32 per turn.
   function automatic logic signed [33:0] atan_entry(input logic [4:0] idx);
      logic signed [33:0] result;
      case (idx)
         5'd0:    result = 34'sh020000000;
         5'd1:    result = 34'sh012E4051E;
         5'd2:    result = 34'sh009FB385B;
         5'd3:    result = 34'sh0051111D4;
         5'd4:    result = 34'sh0028B0D43;
         5'd5:    result = 34'sh00145D7E1;
         5'd6:    result = 34'sh000A2F61E;
         5'd7:    result = 34'sh000517C55;
         5'd8:    result = 34'sh00028BE53;
         5'd9:    result = 34'sh000145F2F;
         5'd10:   result = 34'sh0000A2F98;
         5'd11:   result = 34'sh0000517CC;
         5'd12:   result = 34'sh000028BE6;
         5'd13:   result = 34'sh0000145F3;
         5'd14:   result = 34'sh000000A2FA;
         5'd15:   result = 34'sh00000517D;
         5'd16:   result = 34'sh0000028BE;
         5'd17:   result = 34'sh00000145F;
         5'd18:   result = 34'sh000000A30;
         5'd19:   result = 34'sh000000518;
         5'd20:   result = 34'sh00000028C;
         5'd21:   result = 34'sh000000146;
         5'd22:   result = 34'sh0000000A3;
         5'd23:   result = 34'sh000000051;
         default: result = 34'sh000000000;
      endcase
      return result;
   endfunction

endpackage

>>> design/lsgc_regs.sv
// Configuration registers plus the ray angle and scan phase trackers.
module lsgc_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [lsgc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lsgc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             accept,
   input  logic                             scan_end,
   output lsgc_pkg::cfg_type                cfg,
   output logic [15:0]                      ray_angle,
   output logic                             process
);
   import lsgc_pkg::*;

   logic [15:0]        skip_period_ff;
   logic [15:0]        angle_start_ff;
   logic [15:0]        angle_step_ff;
   logic signed [31:0] origin_x_ff;
   logic signed [31:0] origin_y_ff;
   logic [31:0]        cell_scale_ff;
   logic [12:0]        grid_width_ff;
   logic [12:0]        grid_height_ff;
   logic [15:0]        ray_angle_ff, ray_angle_in;
   logic [15:0]        scan_phase_ff, scan_phase_in;
   logic [16:0]        phase_next;

   always_comb begin
      phase_next    = 17'(scan_phase_ff) + 17'd1;
      ray_angle_in  = ray_angle_ff;
      scan_phase_in = scan_phase_ff;
      if (accept) begin
         if (scan_end) begin
            ray_angle_in = angle_start_ff;
            // A zero period compares like a period of one.
            if (phase_next >= 17'(skip_period_ff)) begin
               scan_phase_in = '0;
            end else begin
               scan_phase_in = phase_next[15:0];
            end
         end else begin
            ray_angle_in = ray_angle_ff + angle_step_ff;
         end
      end
      // Writing the start angle also restarts the current sweep.
      if (csr_wr_en && csr_index_type'(csr_index) == CSR_ANGLE_START) begin
         ray_angle_in = csr_wdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_period_ff <= 16'd1;
         angle_start_ff <= '0;
         angle_step_ff  <= 16'd1;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         cell_scale_ff  <= 32'd335544;
         grid_width_ff  <= 13'd4096;
         grid_height_ff <= 13'd4096;
         ray_angle_ff   <= '0;
         scan_phase_ff  <= '0;
      end else begin
         ray_angle_ff  <= ray_angle_in;
         scan_phase_ff <= scan_phase_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_SKIP_PERIOD: skip_period_ff <= csr_wdata[15:0];
               CSR_ANGLE_START: angle_start_ff <= csr_wdata[15:0];
               CSR_ANGLE_STEP:  angle_step_ff  <= csr_wdata[15:0];
               CSR_ORIGIN_X:    origin_x_ff    <= csr_wdata[31:0];
               CSR_ORIGIN_Y:    origin_y_ff    <= csr_wdata[31:0];
               CSR_CELL_SCALE:  cell_scale_ff  <= csr_wdata[31:0];
               CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[12:0];
               CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[12:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.origin_x   = origin_x_ff;
   assign cfg.origin_y   = origin_y_ff;
   assign cfg.cell_scale = cell_scale_ff;
   assign cfg.grid_w     = clamp_dim(grid_width_ff);
   assign cfg.grid_h     = clamp_dim(grid_height_ff);
   assign ray_angle      = ray_angle_ff;
   assign process        = (scan_phase_ff == 16'd0);

endmodule

>>> design/lsgc_ctrl.sv
// Sequencer that steps one ray through rotation, scaling, range check and output.
module lsgc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 process,
   input  lsgc_pkg::status_type status,
   output lsgc_pkg::cmd_type    cmd,
   output logic                 accept
);
   import lsgc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_SCALE,
      ST_OFFSET,
      ST_MULT,
      ST_CHECK,
      ST_INDEX,
      ST_PUBLISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        mul_ff, mul_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      mul_in   = mul_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            mul_in  = '0;
            // Rays of a skipped scan only move the angle and phase trackers.
            if (accept && process) begin
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROT_STEPS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:  state_in = ST_OFFSET;
         ST_OFFSET: state_in = ST_MULT;
         ST_MULT: begin
            mul_in = mul_ff + 2'd1;
            if (mul_ff == 2'd3) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: state_in = ST_INDEX;
         ST_INDEX: begin
            if (status.hit) begin
               state_in = ST_PUBLISH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         mul_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         mul_ff   <= mul_in;
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.load    = accept;
      cmd.rotate  = (state_ff == ST_ROTATE);
      cmd.step    = 5'(step_ff);
      cmd.scale   = (state_ff == ST_SCALE);
      cmd.offset  = (state_ff == ST_OFFSET);
      cmd.mul     = (state_ff == ST_MULT);
      cmd.mul_sel = mul_ff;
      cmd.check   = (state_ff == ST_CHECK);
      cmd.index   = (state_ff == ST_INDEX);
      cmd.publish = (state_ff == ST_PUBLISH) && status.out_free;
   end

endmodule

>>> design/lsgc_datapath.sv
// CORDIC rotator, shared 32 by 32 multiplier, cell range check and output register.
module lsgc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lsgc_pkg::cmd_type    cmd,
   input  lsgc_pkg::cfg_type    cfg,
   input  logic [15:0]          ray_angle,
   input  logic [15:0]          req_range_mm,
   output lsgc_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [23:0]          rsp_cell_index,
   output logic [11:0]          rsp_cell_x,
   output logic [11:0]          rsp_cell_y
);
   import lsgc_pkg::*;

   logic [15:0]        range_ff;
   logic               neg_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic signed [50:0] prod_x_ff, prod_y_ff;
   logic [62:0]        mag_x_ff, mag_y_ff;
   logic               sgn_x_ff, sgn_y_ff;
   logic [63:0]        hi_x_ff, lo_x_ff, hi_y_ff, lo_y_ff;
   logic [12:0]        cell_x_ff, cell_y_ff;
   logic               hit_ff;
   logic [23:0]        index_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_index_ff;
   logic [11:0]        rsp_x_ff, rsp_y_ff;

   logic signed [15:0] ang;
   logic               fold;
   logic [15:0]        ang_folded;
   logic signed [33:0] xs, ys, at;
   logic signed [33:0] cx, cy;
   logic signed [63:0] d_x, d_y;
   logic [31:0]        mul_a;
   logic [63:0]        mul_p;
   logic [63:0]        t_x, t_y;
   logic [41:0]        q_x, q_y;
   logic               rem_x, rem_y, in_x, in_y;
   logic [12:0]        qcell_x, qcell_y;
   logic [25:0]        index_full;

   // Angles past a quarter turn are turned by a half turn, which flips the top bit.
   always_comb begin
      ang        = signed'(ray_angle);
      fold       = (ang > 16'sd16384) || (ang < -16'sd16384);
      ang_folded = fold ? (ray_angle ^ 16'h8000) : ray_angle;
   end

   always_comb begin
      xs = x_ff >>> cmd.step;
      ys = y_ff >>> cmd.step;
      at = atan_entry(cmd.step);
   end

   always_comb begin
      cx  = neg_ff ? -x_ff : x_ff;
      cy  = neg_ff ? -y_ff : y_ff;
      d_x = {{13{prod_x_ff[50]}}, prod_x_ff} - {{2{cfg.origin_x[31]}}, cfg.origin_x, 30'b0};
      d_y = {{13{prod_y_ff[50]}}, prod_y_ff} - {{2{cfg.origin_y[31]}}, cfg.origin_y, 30'b0};
   end

   always_comb begin
      case (cmd.mul_sel)
         2'd0:    mul_a = {1'b0, mag_x_ff[62:32]};
         2'd1:    mul_a = mag_x_ff[31:0];
         2'd2:    mul_a = {1'b0, mag_y_ff[62:32]};
         default: mul_a = mag_y_ff[31:0];
      endcase
      mul_p = 64'(mul_a) * 64'(cfg.cell_scale);
   end

   // The cell is the magnitude product over 2^54, floored toward minus infinity.
   always_comb begin
      t_x     = hi_x_ff + {32'b0, lo_x_ff[63:32]};
      t_y     = hi_y_ff + {32'b0, lo_y_ff[63:32]};
      q_x     = t_x[63:22];
      q_y     = t_y[63:22];
      rem_x   = (|t_x[21:0]) || (|lo_x_ff[31:0]);
      rem_y   = (|t_y[21:0]) || (|lo_y_ff[31:0]);
      in_x    = sgn_x_ff ? ((q_x == 42'd0) && !rem_x)
                         : ((q_x[41:13] == 29'd0) && (q_x[12:0] < cfg.grid_w));
      in_y    = sgn_y_ff ? ((q_y == 42'd0) && !rem_y)
                         : ((q_y[41:13] == 29'd0) && (q_y[12:0] < cfg.grid_h));
      qcell_x = sgn_x_ff ? 13'd0 : q_x[12:0];
      qcell_y = sgn_y_ff ? 13'd0 : q_y[12:0];
   end

   assign index_full = 26'(cell_y_ff) * 26'(cfg.grid_w) + 26'(cell_x_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         range_ff <= req_range_mm;
         neg_ff   <= fold;
         x_ff     <= CORDIC_GAIN;
         y_ff     <= '0;
         z_ff     <= {{2{ang_folded[15]}}, ang_folded, 16'b0};
      end
      if (cmd.rotate) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
      end
      if (cmd.scale) begin
         prod_x_ff <= $signed({1'b0, range_ff}) * cx;
         prod_y_ff <= $signed({1'b0, range_ff}) * cy;
      end
      if (cmd.offset) begin
         sgn_x_ff <= d_x[63];
         sgn_y_ff <= d_y[63];
         mag_x_ff <= d_x[63] ? 63'(-d_x) : d_x[62:0];
         mag_y_ff <= d_y[63] ? 63'(-d_y) : d_y[62:0];
      end
      if (cmd.mul) begin
         case (cmd.mul_sel)
            2'd0:    hi_x_ff <= mul_p;
            2'd1:    lo_x_ff <= mul_p;
            2'd2:    hi_y_ff <= mul_p;
            default: lo_y_ff <= mul_p;
         endcase
      end
      if (cmd.check) begin
         cell_x_ff <= qcell_x;
         cell_y_ff <= qcell_y;
         hit_ff    <= in_x && in_y;
      end
      if (cmd.index) begin
         index_ff <= index_full[23:0];
      end
      if (cmd.publish) begin
         rsp_index_ff <= index_ff;
         rsp_x_ff     <= cell_x_ff[11:0];
         rsp_y_ff     <= cell_y_ff[11:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.hit      = hit_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_index  = rsp_index_ff;
   assign rsp_cell_x      = rsp_x_ff;
   assign rsp_cell_y      = rsp_y_ff;

endmodule

>>> design/laser_scan_to_grid_cells.sv
// Top level of the laser scan to grid cell block.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  req_range_mm, req_scan_end
//   rsp       out         rsp_valid/rsp_stall  rsp_cell_index, rsp_cell_x, rsp_cell_y
//   csr       in          csr_wr_en            csr_index, csr_wdata
//
// A processed ray runs one CORDIC iteration per cycle, then scaling, offset, four
// passes through the one 32 by 32 multiplier, range check, index and, on a hit,
// the hand-off to the output; req_stall holds off new rays until it is done. A
// ray of a skipped scan leaves the block idle, ready for the next ray. A finished
// cell waits in the output register while the next ray is computed; the block
// holds only if that ray hits and the register is still stalled. Reset is
// synchronous and restores the configuration, tracker, sequencer and output valid
// registers; datapath registers are loaded before use. No clearing pass is needed.
module laser_scan_to_grid_cells (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [15:0]                      req_range_mm,
   input  logic                             req_scan_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [23:0]                      rsp_cell_index,
   output logic [11:0]                      rsp_cell_x,
   output logic [11:0]                      rsp_cell_y,
   input  logic                             csr_wr_en,
   input  logic [lsgc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lsgc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lsgc_pkg::*;

   cfg_type     cfg;
   cmd_type     cmd;
   status_type  status;
   logic [15:0] ray_angle;
   logic        process;
   logic        accept;

   lsgc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .scan_end  (req_scan_end),
      .cfg       (cfg),
      .ray_angle (ray_angle),
      .process   (process)
   );

   lsgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .process   (process),
      .status    (status),
      .cmd       (cmd),
      .accept    (accept)
   );

   lsgc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .ray_angle      (ray_angle),
      .req_range_mm   (req_range_mm),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_index (rsp_cell_index),
      .rsp_cell_x     (rsp_cell_x),
      .rsp_cell_y     (rsp_cell_y)
   );

endmodule

>>> design/lsgc_checker.sv
// Port level checker for the scan to grid block and its bind statement.
`include "assert_macros.svh"

module lsgc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [23:0]                      rsp_cell_index,
   input logic [11:0]                      rsp_cell_x,
   input logic [11:0]                      rsp_cell_y,
   input logic                             csr_wr_en,
   input logic [lsgc_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [lsgc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lsgc_pkg::*;

   logic [12:0] width_ff, height_ff;
   logic [12:0] w_chk, h_chk;
   logic [23:0] index_expect;
   logic [25:0] index_full;

   // Shadow copies of the grid size, taken from the write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd4096;
         height_ff <= 13'd4096;
      end else if (csr_wr_en) begin
         if (csr_index_type'(csr_index) == CSR_GRID_WIDTH) begin
            width_ff <= csr_wdata[12:0];
         end
         if (csr_index_type'(csr_index) == CSR_GRID_HEIGHT) begin
            height_ff <= csr_wdata[12:0];
         end
      end
   end

   always_comb begin
      w_chk        = clamp_dim(width_ff);
      h_chk        = clamp_dim(height_ff);
      index_full   = 26'(rsp_cell_y) * 26'(w_chk) + 26'(rsp_cell_x);
      index_expect = index_full[23:0];
   end

   `LSGC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "rsp beat valid after reset")
   `LSGC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_index) && $stable(rsp_cell_x) && $stable(rsp_cell_y), "stalled rsp beat changed")
   `LSGC_ASSERT(a_cell_in_grid, clock, reset, rsp_valid |-> (13'(rsp_cell_x) < w_chk) && (13'(rsp_cell_y) < h_chk), "rsp cell outside the grid")
   `LSGC_ASSERT(a_index_match, clock, reset, rsp_valid |-> rsp_cell_index == index_expect, "rsp cell index does not match row and column")

endmodule

bind laser_scan_to_grid_cells lsgc_checker u_lsgc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_cell_index (rsp_cell_index),
   .rsp_cell_x     (rsp_cell_x),
   .rsp_cell_y     (rsp_cell_y),
   .csr_wr_en      (csr_wr_en),
   .csr_index      (csr_index),
   .csr_wdata      (csr_wdata)
);
